// File: hw/rtl/source_rate_flood_detector_macros.svh
// Assertion macros shared by the checker of source_rate_flood_detector.
// Holds only the include guard and the macro definitions; no dependencies.
`ifndef SOURCE_RATE_FLOOD_DETECTOR_MACROS_SVH
`define SOURCE_RATE_FLOOD_DETECTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in source_rate_flood_detector");

// Next-cycle implication, checked on every rising edge outside reset.
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in source_rate_flood_detector");

`endif

// File: hw/rtl/sfd_pkg.sv
// Package of the source rate flood detector: payload structs, codes, cell control.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned IP_W  = 32;
    localparam int unsigned CNT_W = 32;

    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic KIND_FLAG = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(100);

    typedef struct packed {
        logic            mode;
        logic [IP_W-1:0] source_ip;
    } in_t;

    typedef struct packed {
        logic             kind;
        logic [IP_W-1:0]  flagged_ip;
        logic [CNT_W-1:0] hit_total;
        logic             last;
    } out_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // compare the incoming address and register the match
        logic upd;      // apply the registered match: count up or allocate
        logic any_hit;  // some cell matched, so no cell allocates
        logic shift;    // every cell takes its upper neighbor's contents
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// File: hw/rtl/sfd_cell.sv
// One slot of the source table: stored address, window count and match flag.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_cell (
    input  logic                            aclk,
    input  sfd_pkg::cell_ctl_t              ctl,
    input  logic                            occupied,
    input  logic                            alloc_slot,
    input  logic [sfd_pkg::IP_W-1:0]        cmp_ip,
    input  logic [sfd_pkg::IP_W-1:0]        new_ip,
    input  logic [sfd_pkg::IP_W-1:0]        nbr_ip,
    input  logic [sfd_pkg::CNT_W-1:0]       nbr_cnt,
    output logic [sfd_pkg::IP_W-1:0]        ip,
    output logic [sfd_pkg::CNT_W-1:0]       cnt,
    output logic                            hit
);
    import sfd_pkg::*;

    logic [IP_W-1:0]  ip_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            hit_reg <= occupied && (ip_reg == cmp_ip);
        end
        if (ctl.shift) begin
            ip_reg  <= nbr_ip;
            cnt_reg <= nbr_cnt;
        end else if (ctl.upd) begin
            if (hit_reg) begin
                // The count saturates at its maximum.
                if (cnt_reg != {CNT_W{1'b1}}) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end else if (!ctl.any_hit && alloc_slot) begin
                ip_reg  <= new_ip;
                cnt_reg <= CNT_W'(1);
            end
        end
    end

    assign ip  = ip_reg;
    assign cnt = cnt_reg;
    assign hit = hit_reg;

endmodule

// File: hw/rtl/source_rate_flood_detector.sv
// Top level of the source rate flood detector: sequencer, output stage, cell row.
// Depends on sfd_pkg and sfd_cell.
`timescale 1ns / 1ps

// Usage:
// The input channel (s_valid, s_ready, s_data) takes packet events (mode 0,
// with a source address) and window ticks (mode 1). The result channel
// (m_valid, m_ready, m_data) returns flagged sources and drop reports; last
// marks the final result caused by one input transfer. The cfg channel
// writes the flood threshold and is always ready; write it only while idle.
// For a packet event every cell compares the address in the cycle of the
// transfer and registers its match, and the next cycle counts up the
// matching cell or allocates the first free slot. When the table is full
// and no cell matches, the event is dropped and one result with kind 1 is
// produced. For a tick the cell row shifts toward slot 0 once per cycle
// unless paused and the sequencer inspects slot 0, so the length of the
// scan is set by the number of occupied slots; the flush state then hands
// over the held result. One flagged result is held back so that the final
// one can be marked last. After the scan the table is empty.
// A stalled receiver holds the output register; a drop report waits for it,
// and the scan pauses only when a second flagged result needs the output
// register while it is still full.
// Reset (aresetn low at a clock edge) empties the table, clears the output
// valid flag and loads the threshold with 100. No clearing pass is needed.
module source_rate_flood_detector #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sfd_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sfd_pkg::out_t                m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sfd_pkg::CNT_W-1:0]    cfg_data
);
    import sfd_pkg::*;

    localparam int unsigned OCC_W = $clog2(TABLE_ENTRIES + 1);

    state_t           state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] thresh_reg;
    logic [IP_W-1:0]  pkt_ip_reg;
    logic             m_valid_reg;
    out_t             m_data_reg, out_next;
    logic             pend_valid_reg;
    out_t             pend_reg;

    logic             out_load;
    logic             pend_load;
    logic             pend_clr;
    logic             out_free;
    logic             flagged;
    logic             any_hit;
    logic             table_full;
    cell_ctl_t        ctl;

    // Cell row; the entry above the top cell feeds zeros into the shift.
    logic [IP_W-1:0]          cell_ip  [TABLE_ENTRIES+1];
    logic [CNT_W-1:0]         cell_cnt [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] hit_vec;

    assign cell_ip[TABLE_ENTRIES]  = '0;
    assign cell_cnt[TABLE_ENTRIES] = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        sfd_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .occupied   (occ_reg > OCC_W'(i)),
            .alloc_slot (occ_reg == OCC_W'(i)),
            .cmp_ip     (s_data.source_ip),
            .new_ip     (pkt_ip_reg),
            .nbr_ip     (cell_ip[i+1]),
            .nbr_cnt    (cell_cnt[i+1]),
            .ip         (cell_ip[i]),
            .cnt        (cell_cnt[i]),
            .hit        (hit_vec[i])
        );
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign flagged    = cell_cnt[0] > thresh_reg;
    assign any_hit    = |hit_vec;
    assign table_full = (occ_reg == OCC_W'(TABLE_ENTRIES));

    always_comb begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        scan_next   = scan_reg;
        s_ready     = 1'b0;
        ctl         = '0;
        ctl.any_hit = any_hit;
        out_load    = 1'b0;
        out_next    = pend_reg;
        pend_load   = 1'b0;
        pend_clr    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.cmp_en = 1'b1;
                    if (s_data.mode == MODE_TICK) begin
                        scan_next  = occ_reg;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                ctl.upd = 1'b1;
                if (any_hit) begin
                    state_next = ST_IDLE;
                end else if (!table_full) begin
                    occ_next   = occ_reg + OCC_W'(1);
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // Table full: report the dropped source.
                    out_load            = 1'b1;
                    out_next.kind       = KIND_DROP;
                    out_next.flagged_ip = pkt_ip_reg;
                    out_next.hit_total  = '0;
                    out_next.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_reg == '0) begin
                    occ_next   = '0;
                    state_next = ST_FLUSH;
                end else if (!(flagged && pend_valid_reg && !out_free)) begin
                    ctl.shift = 1'b1;
                    scan_next = scan_reg - OCC_W'(1);
                    if (flagged) begin
                        pend_load = 1'b1;
                        if (pend_valid_reg) begin
                            out_load      = 1'b1;
                            out_next.last = 1'b0;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load      = 1'b1;
                    out_next.last = 1'b1;
                    pend_clr      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            scan_reg       <= '0;
            thresh_reg     <= THRESH_RESET;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            scan_reg  <= scan_next;
            if (cfg_valid) begin
                thresh_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pend_load) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_clr) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pkt_ip_reg <= s_data.source_ip;
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
        if (pend_load) begin
            pend_reg.kind       <= KIND_FLAG;
            pend_reg.flagged_ip <= cell_ip[0];
            pend_reg.hit_total  <= cell_cnt[0];
            pend_reg.last       <= 1'b0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: hw/rtl/sfd_checker.sv
// Port-level checker of the source rate flood detector and its bind statement.
// Depends on sfd_pkg and source_rate_flood_detector_macros.svh.
`timescale 1ns / 1ps
`include "source_rate_flood_detector_macros.svh"

module sfd_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  sfd_pkg::in_t                 s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  sfd_pkg::out_t                m_data
);
    import sfd_pkg::*;

    // A result that is not taken stays offered and unchanged.
    `SFD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // A drop report is always the only and final result of its event.
    `SFD_ASSERT_SAME(a_drop_form, m_valid && (m_data.kind == KIND_DROP),
        m_data.last && (m_data.hit_total == '0))

    // A flagged source has exceeded a threshold, so its count is never zero.
    `SFD_ASSERT_SAME(a_flag_count, m_valid && (m_data.kind == KIND_FLAG),
        m_data.hit_total != '0)

    // A packet event keeps the input closed for its update cycle.
    `SFD_ASSERT_NEXT(a_pkt_gap, s_valid && s_ready && (s_data.mode == MODE_PACKET),
        !s_ready)

endmodule

bind source_rate_flood_detector sfd_checker u_sfd_checker (.*);
